@@ src/xcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, codes and the CRC-16 byte update of the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package xcrc_pkg;

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_TIMEOUT = 2'd1,
      CMD_START   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_DATA    = 3'd1,
      KIND_ERASE   = 3'd2,
      KIND_COMMIT  = 3'd3,
      KIND_DISCARD = 3'd4,
      KIND_END     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_NUMBER = 3'd1,
      PH_COMPL  = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRCH   = 3'd4,
      PH_CRCL   = 3'd5,
      PH_IDLE   = 3'd6
   } phase_type;

   localparam logic       CSR_MAX_ERRORS   = 1'b0;
   localparam logic       CSR_SECTOR_SHIFT = 1'b1;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0]  ERR_SAT  = 8'hFF;

   // one bit per possible response, in delivery order
   localparam int ACT_DATA    = 0;
   localparam int ACT_ERASE0  = 1;
   localparam int ACT_ERASE   = 2;
   localparam int ACT_COMMIT  = 3;
   localparam int ACT_DISCARD = 4;
   localparam int ACT_SEND    = 5;
   localparam int ACT_CAN1    = 6;
   localparam int ACT_CAN2    = 7;
   localparam int ACT_END     = 8;
   localparam int ACT_NUM     = 9;

   typedef struct packed {
      logic [ACT_NUM-1:0] mask;
      logic [7:0]         data_byte;
      logic [19:0]        data_off;
      logic [9:0]         sector;
      logic [19:0]        commit_off;
      logic [7:0]         send_byte;
      logic               end_status;
   } action_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ src/xcrc_fifo.sv @@
// ----------------------------------------------------------------------------
// xcrc_fifo
// Two-entry queue of decoded actions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module xcrc_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  xcrc_pkg::action_type    push_data,
   output logic                    full,
   input  wire                     pop,
   output logic                    pop_valid,
   output xcrc_pkg::action_type    pop_data
);
   import xcrc_pkg::*;

   action_type  mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ src/xcrc_front.sv @@
// ----------------------------------------------------------------------------
// xcrc_front
// Packet parser: tracks framing, CRC and error count, emits at most one action per request.
// ----------------------------------------------------------------------------
`default_nettype none
module xcrc_front #(
   parameter int OFFSET_BITS = 20
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire  [1:0]              cmd,
   input  wire  [7:0]              rx_byte,
   input  wire  [7:0]              max_errors,
   input  wire  [4:0]              sector_shift,
   output logic                    push,
   output xcrc_pkg::action_type    action
);
   import xcrc_pkg::*;

   localparam int OB = OFFSET_BITS;

   phase_type     phase_ff, phase_in;
   logic          long_ff, long_in;
   logic [7:0]    expected_ff, expected_in;
   logic [7:0]    number_ff, number_in;
   logic [7:0]    compl_ff, compl_in;
   logic [10:0]   idx_ff, idx_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crc_high_ff, crc_high_in;
   logic [OB-1:0] offset_ff, offset_in;
   logic [7:0]    err_ff, err_in;
   logic          first_ff, first_in;

   logic [OB:0]   end_w, cur_sec, nxt_sec;
   logic [OB-1:0] data_off;
   logic [10:0]   idx_next, size_w;
   logic [7:0]    err_inc;
   logic          abort, ok, err_event, is_byte, is_tmo, in_packet;
   cmd_type       cmd_c;

   assign cmd_c     = cmd_type'(cmd);
   assign is_byte   = accept && (cmd_c == CMD_BYTE);
   assign is_tmo    = accept && (cmd_c == CMD_TIMEOUT);
   assign size_w    = long_ff ? 11'd1024 : 11'd128;
   assign idx_next  = idx_ff + 11'd1;
   assign end_w     = {1'b0, offset_ff} + (OB+1)'(size_w);
   assign data_off  = offset_ff + OB'(idx_ff);
   assign cur_sec   = {1'b0, offset_ff} >> sector_shift;
   assign nxt_sec   = end_w >> sector_shift;
   assign err_inc   = (err_ff == ERR_SAT) ? err_ff : err_ff + 8'd1;
   assign abort     = (err_inc >= max_errors);
   assign in_packet = (phase_ff != PH_HEADER) && (phase_ff != PH_IDLE);
   assign ok = (number_ff == expected_ff)
            && ((9'(number_ff) + 9'(compl_ff)) == 9'd255)
            && ({crc_high_ff, rx_byte} == crc_ff)
            && !(end_w[OB] && (end_w[OB-1:0] != '0));

   assign err_event =
        (is_byte && (phase_ff == PH_HEADER) && (rx_byte != CH_SOH) && (rx_byte != CH_STX)
                 && (rx_byte != CH_EOT) && (rx_byte != CH_CAN))
     || (is_byte && (phase_ff == PH_CRCL) && !ok)
     || (is_tmo && (phase_ff == PH_HEADER) && first_ff)
     || (is_tmo && in_packet);

   function automatic logic [19:0] cut20(input logic [OB-1:0] x);
      logic [32:0] t;
      t = 33'(x);
      return t[19:0];
   endfunction

   // next state
   always_comb begin
      phase_in    = phase_ff;
      long_in     = long_ff;
      expected_in = expected_ff;
      number_in   = number_ff;
      compl_in    = compl_ff;
      idx_in      = idx_ff;
      crc_in      = crc_ff;
      crc_high_in = crc_high_ff;
      offset_in   = offset_ff;
      err_in      = err_ff;
      first_in    = first_ff;
      if (accept && (cmd_c == CMD_START)) begin
         phase_in    = PH_HEADER;
         long_in     = 1'b0;
         expected_in = 8'd1;
         number_in   = 8'd0;
         compl_in    = 8'd0;
         idx_in      = 11'd0;
         crc_in      = 16'd0;
         crc_high_in = 8'd0;
         offset_in   = '0;
         err_in      = 8'd0;
         first_in    = 1'b0;
      end else if (is_byte) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if ((rx_byte == CH_SOH) || (rx_byte == CH_STX)) begin
                  long_in  = (rx_byte == CH_STX);
                  phase_in = PH_NUMBER;
               end else if ((rx_byte == CH_EOT) || (rx_byte == CH_CAN)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_NUMBER: begin
               number_in = rx_byte;
               phase_in  = PH_COMPL;
            end
            PH_COMPL: begin
               compl_in = rx_byte;
               idx_in   = 11'd0;
               crc_in   = 16'd0;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               crc_in = crc_byte(crc_ff, rx_byte);
               idx_in = idx_next;
               if (idx_next >= size_w) begin
                  phase_in = PH_CRCH;
               end
            end
            PH_CRCH: begin
               crc_high_in = rx_byte;
               phase_in    = PH_CRCL;
            end
            PH_CRCL: begin
               first_in = 1'b1;
               if (ok) begin
                  expected_in = expected_ff + 8'd1;
                  offset_in   = end_w[OB-1:0];
                  phase_in    = PH_HEADER;
               end
            end
            PH_IDLE: begin
            end
            default: begin
            end
         endcase
      end
      if (err_event) begin
         err_in   = err_inc;
         phase_in = abort ? PH_IDLE : PH_HEADER;
      end
   end

   // action decode
   always_comb begin
      action = '0;
      if (is_byte) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (rx_byte == CH_EOT) begin
                  action.mask[ACT_SEND] = 1'b1;
                  action.send_byte      = CH_ACK;
                  action.mask[ACT_END]  = 1'b1;
               end else if (rx_byte == CH_CAN) begin
                  action.mask[ACT_END]  = 1'b1;
                  action.end_status     = 1'b1;
               end
            end
            PH_DATA: begin
               action.mask[ACT_DATA] = 1'b1;
               action.data_byte      = rx_byte;
               action.data_off       = cut20(data_off);
            end
            PH_CRCL: begin
               action.mask[ACT_ERASE0] = !first_ff;
               if (ok) begin
                  action.mask[ACT_ERASE]  = (cur_sec != nxt_sec);
                  action.sector           = nxt_sec[9:0];
                  action.mask[ACT_COMMIT] = 1'b1;
                  action.commit_off       = cut20(offset_ff);
                  action.mask[ACT_SEND]   = 1'b1;
                  action.send_byte        = CH_ACK;
               end else begin
                  action.mask[ACT_DISCARD] = 1'b1;
               end
            end
            PH_NUMBER, PH_COMPL, PH_CRCH, PH_IDLE: begin
            end
            default: begin
            end
         endcase
      end else if (is_tmo) begin
         if ((phase_ff == PH_HEADER) && !first_ff) begin
            action.mask[ACT_SEND] = 1'b1;
            action.send_byte      = CH_C;
         end else if (in_packet) begin
            action.mask[ACT_DISCARD] = 1'b1;
         end
      end
      if (err_event) begin
         if (abort) begin
            action.mask[ACT_CAN1] = 1'b1;
            action.mask[ACT_CAN2] = 1'b1;
            action.mask[ACT_END]  = 1'b1;
            action.end_status     = 1'b1;
         end else begin
            action.mask[ACT_SEND] = 1'b1;
            action.send_byte      = CH_NAK;
         end
      end
   end

   assign push = (action.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         long_ff     <= 1'b0;
         expected_ff <= 8'd1;
         number_ff   <= 8'd0;
         compl_ff    <= 8'd0;
         idx_ff      <= 11'd0;
         crc_ff      <= 16'd0;
         crc_high_ff <= 8'd0;
         offset_ff   <= '0;
         err_ff      <= 8'd0;
         first_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         long_ff     <= long_in;
         expected_ff <= expected_in;
         number_ff   <= number_in;
         compl_ff    <= compl_in;
         idx_ff      <= idx_in;
         crc_ff      <= crc_in;
         crc_high_ff <= crc_high_in;
         offset_ff   <= offset_in;
         err_ff      <= err_in;
         first_ff    <= first_in;
      end
   end

endmodule
`default_nettype wire

@@ src/xcrc_back.sv @@
// ----------------------------------------------------------------------------
// xcrc_back
// Response sequencer: expands each queued action into responses, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module xcrc_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     q_valid,
   input  xcrc_pkg::action_type    q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [2:0]              rsp_kind,
   output logic [7:0]              rsp_tx_byte,
   output logic [7:0]              rsp_data_byte,
   output logic [19:0]             rsp_offset,
   output logic [9:0]              rsp_sector,
   output logic                    rsp_end_status,
   output logic                    rsp_last
);
   import xcrc_pkg::*;

   action_type         work_ff, work_in;
   logic [ACT_NUM-1:0] sel, rest;
   logic               out_free, emit;
   logic               valid_ff, valid_in;
   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         tx_ff, tx_in, data_ff, data_in;
   logic [19:0]        off_ff, off_in;
   logic [9:0]         sec_ff, sec_in;
   logic               endst_ff, endst_in, last_ff, last_in;

   assign sel      = work_ff.mask & (~work_ff.mask + ACT_NUM'(1));
   assign rest     = work_ff.mask & ~sel;
   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = out_free && (work_ff.mask != '0);
   assign q_pop    = q_valid && ((work_ff.mask == '0) || (emit && (rest == '0)));

   always_comb begin
      work_in = work_ff;
      if (q_pop) begin
         work_in = q_data;
      end else if (emit) begin
         work_in.mask = rest;
      end
   end

   always_comb begin
      valid_in = out_free ? emit : valid_ff;
      kind_in  = kind_ff;
      tx_in    = tx_ff;
      data_in  = data_ff;
      off_in   = off_ff;
      sec_in   = sec_ff;
      endst_in = endst_ff;
      last_in  = last_ff;
      if (emit) begin
         kind_in  = KIND_SEND;
         tx_in    = 8'd0;
         data_in  = 8'd0;
         off_in   = 20'd0;
         sec_in   = 10'd0;
         endst_in = 1'b0;
         last_in  = (rest == '0);
         if (sel[ACT_DATA]) begin
            kind_in = KIND_DATA;
            data_in = work_ff.data_byte;
            off_in  = work_ff.data_off;
         end else if (sel[ACT_ERASE0]) begin
            kind_in = KIND_ERASE;
         end else if (sel[ACT_ERASE]) begin
            kind_in = KIND_ERASE;
            sec_in  = work_ff.sector;
         end else if (sel[ACT_COMMIT]) begin
            kind_in = KIND_COMMIT;
            off_in  = work_ff.commit_off;
         end else if (sel[ACT_DISCARD]) begin
            kind_in = KIND_DISCARD;
         end else if (sel[ACT_SEND]) begin
            tx_in = work_ff.send_byte;
         end else if (sel[ACT_CAN1] || sel[ACT_CAN2]) begin
            tx_in = CH_CAN;
         end else begin
            kind_in  = KIND_END;
            endst_in = work_ff.end_status;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_tx_byte    = tx_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_offset     = off_ff;
   assign rsp_sector     = sec_ff;
   assign rsp_end_status = endst_ff;
   assign rsp_last       = last_ff;

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      tx_ff    <= tx_in;
      data_ff  <= data_in;
      off_ff   <= off_in;
      sec_ff   <= sec_in;
      endst_ff <= endst_in;
      last_ff  <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
         work_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         work_ff  <= work_in;
      end
   end

endmodule
`default_nettype wire

@@ src/xmodem_crc_receiver.sv @@
// Each action passes through the queue, the work register and the response register.
// Throughput: one request per cycle while each yields at most one response and
// rsp_stall is low; the response register drains one response per cycle, so requests
// that yield several (up to five) hold the input back through the two-entry queue.
// Reset: synchronous; clears parser state, queue and response valid, and loads
// max_errors = 3 and sector_shift = 12.
// ----------------------------------------------------------------------------
// xmodem_crc_receiver
// XMODEM-CRC / 1K receiver: parser front, action queue and response sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module xmodem_crc_receiver #(
   parameter int OFFSET_BITS = 20
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_cmd,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_data_byte,
   output logic [19:0] rsp_offset,
   output logic [9:0]  rsp_sector,
   output logic        rsp_end_status,
   output logic        rsp_last,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata
);
   import xcrc_pkg::*;

   logic [7:0] max_err_ff, max_err_in;
   logic [4:0] shift_ff, shift_in;
   logic       accept, push, full, pop, q_valid;
   action_type act, q_data;

   always_comb begin
      max_err_in = max_err_ff;
      shift_in   = shift_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_ERRORS:   max_err_in = csr_wdata;
            CSR_SECTOR_SHIFT: shift_in   = csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_err_ff <= 8'd3;
         shift_ff   <= 5'd12;
      end else begin
         max_err_ff <= max_err_in;
         shift_ff   <= shift_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   xcrc_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .rx_byte      (req_rx_byte),
      .max_errors   (max_err_ff),
      .sector_shift (shift_ff),
      .push         (push),
      .action       (act)
   );

   xcrc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (act),
      .full      (full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   xcrc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_offset     (rsp_offset),
      .rsp_sector     (rsp_sector),
      .rsp_end_status (rsp_end_status),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

@@ src/xcrc_checker.sv @@
// ----------------------------------------------------------------------------
// xcrc_checker
// Port-level checks on the receiver's response channel.
// ----------------------------------------------------------------------------
`default_nettype none
module xcrc_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [2:0]  rsp_kind,
   input wire [7:0]  rsp_tx_byte,
   input wire [19:0] rsp_offset,
   input wire        rsp_last
);
   import xcrc_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind <= KIND_END))
      else $error("response kind out of range");

   a_tx_only_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_SEND)) |-> (rsp_tx_byte == 8'd0))
      else $error("tx byte on non-send response");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_END)) |-> rsp_last)
      else $error("end response not last");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_offset)))
      else $error("stalled response changed");

endmodule

bind xmodem_crc_receiver xcrc_checker u_checker (.*);
`default_nettype wire

@@ dv/tb_xmodem_crc_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_xmodem_crc_receiver
// Self-checking testbench for the XMODEM-CRC/1K receiver. Requests come from a
// queue filled by directed and random packet streams. A behavioral model of the
// receiver predicts the responses, and a monitor checks them in order. The
// sender and receiver sides idle at random, in several patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_xmodem_crc_receiver;
   import xcrc_pkg::*;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tx;
      logic [7:0]  data;
      logic [19:0] off;
      logic [9:0]  sector;
      logic        end_status;
      logic        last;
   } rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic [7:0]  rsp_data_byte;
   logic [19:0] rsp_offset;
   logic [9:0]  rsp_sector;
   logic        rsp_end_status;
   logic        rsp_last;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   xmodem_crc_receiver dut (.*);

   req_type   pending_reqs[$];
   rsp_type   expected_rsps[$];
   int        mismatches;
   int        send_idle_pct;
   int        recv_idle_pct;

   // model state
   logic [7:0]  m_max_err;
   logic [4:0]  m_shift;
   phase_type   m_phase;
   logic        m_long;
   logic [7:0]  m_exp_num;
   logic [7:0]  m_num;
   logic [7:0]  m_cmp;
   logic [10:0] m_idx;
   logic [15:0] m_crc;
   logic [7:0]  m_crc_hi;
   logic [19:0] m_img_off;
   logic [7:0]  m_err;
   logic        m_first;
   rsp_type     step_rsps[$];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic rsp_type mk(kind_type k, logic [7:0] tx, logic [7:0] d,
                                  logic [19:0] o, logic [9:0] s, logic e);
      rsp_type r;
      r = '{kind: k, tx: tx, data: d, off: o, sector: s, end_status: e, last: 1'b0};
      return r;
   endfunction

   task automatic clear_transfer();
      m_phase = PH_HEADER;
      m_long = 1'b0;
      m_exp_num = 8'd1;
      m_num = '0;
      m_cmp = '0;
      m_idx = '0;
      m_crc = '0;
      m_crc_hi = '0;
      m_img_off = '0;
      m_err = '0;
      m_first = 1'b0;
   endtask

   task automatic count_error();
      if (m_err != 8'hFF) m_err++;
      if (m_err >= m_max_err) begin
         step_rsps.push_back(mk(KIND_SEND, CH_CAN, 0, 0, 0, 0));
         step_rsps.push_back(mk(KIND_SEND, CH_CAN, 0, 0, 0, 0));
         step_rsps.push_back(mk(KIND_END, 0, 0, 0, 0, 1));
         m_phase = PH_IDLE;
      end else begin
         step_rsps.push_back(mk(KIND_SEND, CH_NAK, 0, 0, 0, 0));
         m_phase = PH_HEADER;
      end
   endtask

   task automatic finish_packet(logic [7:0] lo);
      logic [20:0] size;
      logic [20:0] stop;
      logic        ok;
      size = m_long ? 21'd1024 : 21'd128;
      stop = {1'b0, m_img_off} + size;
      if (!m_first) begin
         step_rsps.push_back(mk(KIND_ERASE, 0, 0, 0, 0, 0));
         m_first = 1'b1;
      end
      ok = (m_num == m_exp_num) && (9'(m_num) + 9'(m_cmp) == 9'd255)
           && ({m_crc_hi, lo} == m_crc) && (stop <= 21'h100000);
      if (ok) begin
         if (({1'b0, m_img_off} >> m_shift) != (stop >> m_shift))
            step_rsps.push_back(mk(KIND_ERASE, 0, 0, 0, 10'(stop >> m_shift), 0));
         step_rsps.push_back(mk(KIND_COMMIT, 0, 0, m_img_off, 0, 0));
         step_rsps.push_back(mk(KIND_SEND, CH_ACK, 0, 0, 0, 0));
         m_exp_num++;
         m_img_off = stop[19:0];
         m_phase = PH_HEADER;
      end else begin
         step_rsps.push_back(mk(KIND_DISCARD, 0, 0, 0, 0, 0));
         count_error();
      end
   endtask

   task automatic predict_request(req_type r);
      step_rsps = {};
      if (r.cmd == CMD_BYTE) begin
         case (m_phase)
            PH_HEADER: begin
               if (r.rx == CH_SOH || r.rx == CH_STX) begin
                  m_long = (r.rx == CH_STX);
                  m_phase = PH_NUMBER;
               end else if (r.rx == CH_EOT) begin
                  step_rsps.push_back(mk(KIND_SEND, CH_ACK, 0, 0, 0, 0));
                  step_rsps.push_back(mk(KIND_END, 0, 0, 0, 0, 0));
                  m_phase = PH_IDLE;
               end else if (r.rx == CH_CAN) begin
                  step_rsps.push_back(mk(KIND_END, 0, 0, 0, 0, 1));
                  m_phase = PH_IDLE;
               end else begin
                  count_error();
               end
            end
            PH_NUMBER: begin
               m_num = r.rx;
               m_phase = PH_COMPL;
            end
            PH_COMPL: begin
               m_cmp = r.rx;
               m_idx = '0;
               m_crc = '0;
               m_phase = PH_DATA;
            end
            PH_DATA: begin
               step_rsps.push_back(mk(KIND_DATA, 0, r.rx, m_img_off + 20'(m_idx), 0, 0));
               m_crc = crc_update(m_crc, r.rx);
               m_idx++;
               if (m_idx >= (m_long ? 11'd1024 : 11'd128)) m_phase = PH_CRCH;
            end
            PH_CRCH: begin
               m_crc_hi = r.rx;
               m_phase = PH_CRCL;
            end
            PH_CRCL: finish_packet(r.rx);
            default: ;
         endcase
      end else if (r.cmd == CMD_TIMEOUT) begin
         if (m_phase == PH_HEADER) begin
            if (!m_first) step_rsps.push_back(mk(KIND_SEND, CH_C, 0, 0, 0, 0));
            else count_error();
         end else if (m_phase != PH_IDLE) begin
            step_rsps.push_back(mk(KIND_DISCARD, 0, 0, 0, 0, 0));
            count_error();
         end
      end else if (r.cmd == CMD_START) begin
         clear_transfer();
      end
      if (step_rsps.size() > 0) step_rsps[step_rsps.size()-1].last = 1'b1;
      foreach (step_rsps[i]) expected_rsps.push_back(step_rsps[i]);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_request('{cmd: req_cmd, rx: req_rx_byte});
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_cmd <= pending_reqs[0].cmd;
            req_rx_byte <= pending_reqs[0].rx;
            void'(pending_reqs.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response kind", rsp_kind, 0);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_kind != e.kind) report_mismatch("kind", rsp_kind, e.kind);
               if (rsp_tx_byte != e.tx) report_mismatch("tx_byte", rsp_tx_byte, e.tx);
               if (rsp_data_byte != e.data)
                  report_mismatch("data_byte", rsp_data_byte, e.data);
               if (rsp_offset != e.off) report_mismatch("offset", rsp_offset, e.off);
               if (rsp_sector != e.sector) report_mismatch("sector", rsp_sector, e.sector);
               if (rsp_end_status != e.end_status)
                  report_mismatch("end_status", rsp_end_status, e.end_status);
               if (rsp_last != e.last) report_mismatch("last", rsp_last, e.last);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic push_req(cmd_type c, logic [7:0] b);
      pending_reqs.push_back('{cmd: c, rx: b});
   endtask

   // flaw: 0 clean, 1 bad number, 2 bad complement, 3 bad crc, 4 truncated
   task automatic push_packet(logic is_long, logic [7:0] num, int flaw, bit rand_data);
      logic [15:0] crc;
      logic [7:0]  d;
      int          n;
      crc = '0;
      n = is_long ? 1024 : 128;
      push_req(CMD_BYTE, is_long ? CH_STX : CH_SOH);
      push_req(CMD_BYTE, flaw == 1 ? num + 8'd1 : num);
      push_req(CMD_BYTE, flaw == 2 ? ~num + 8'd1 : ~num);
      for (int i = 0; i < n; i++) begin
         if (flaw == 4 && i == 2) begin
            push_req(CMD_TIMEOUT, 8'($urandom));
            return;
         end
         d = rand_data ? 8'($urandom) : (i[0] ? 8'hFF : 8'h00);
         push_req(CMD_BYTE, d);
         crc = crc_update(crc, d);
      end
      if (flaw == 3) crc ^= 16'h0100;
      push_req(CMD_BYTE, crc[15:8]);
      push_req(CMD_BYTE, crc[7:0]);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_ERRORS) m_max_err = val;
      else m_shift = val[4:0];
   endtask

   task automatic random_transfer(int npk);
      int r;
      push_req(CMD_START, 8'($urandom));
      if ($urandom_range(1)) push_req(CMD_TIMEOUT, 8'($urandom));
      for (int p = 0; p < npk; p++) begin
         r = $urandom_range(99);
         if (r < 50) begin
            push_packet($urandom_range(1) == 1, 8'($urandom), 4, 1);
         end else if (r < 75) begin
            push_req(CMD_BYTE, 8'($urandom));
         end else begin
            push_req(cmd_type'($urandom_range(1) ? 2'd1 : 2'd3), 8'($urandom));
         end
      end
      r = $urandom_range(3);
      if (r == 0) push_req(CMD_BYTE, CH_CAN);
      else push_req(CMD_BYTE, CH_EOT);
      push_req(CMD_BYTE, 8'($urandom));
   endtask

   initial begin
      mismatches = 0;
      send_idle_pct = 35;
      recv_idle_pct = 81;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_BYTE;
      req_rx_byte = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MAX_ERRORS;
      csr_wdata = '0;
      m_max_err = 8'd3;
      m_shift = 5'd12;
      clear_transfer();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: timeout for C, good packet, EOT, idle, restart, header error
      push_req(CMD_TIMEOUT, 8'h00);
      push_packet(1'b0, 8'd1, 0, 1);
      push_req(CMD_BYTE, CH_EOT);
      push_req(CMD_BYTE, 8'hFF);
      push_req(CMD_START, 8'h00);
      push_req(cmd_type'(2'd3), 8'hAA);
      push_req(CMD_BYTE, 8'h55);
      push_req(CMD_TIMEOUT, 8'h00);
      wait_idle();
      write_csr(CSR_MAX_ERRORS, 8'd255);
      write_csr(CSR_SECTOR_SHIFT, 8'd10);
      push_req(CMD_START, 8'h00);
      push_packet(1'b1, 8'd1, 4, 1);
      push_req(CMD_BYTE, CH_CAN);
      wait_idle();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 35 : (ph == 1 ? 81 : 0);
         recv_idle_pct = ph == 0 ? 81 : (ph == 1 ? 35 : 0);
         write_csr(CSR_MAX_ERRORS, ph == 0 ? 8'd1 : 8'($urandom_range(2, 8)));
         write_csr(CSR_SECTOR_SHIFT, ph == 2 ? 8'd16 : 8'($urandom_range(10, 16)));
         random_transfer(2);
         wait_idle();
      end

      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
